// ===== sv/sfs_pkg.sv =====
// Shared types and constants for the shift queue with search.
package sfs_pkg;

   localparam int DEPTH_DEF = 16;

   localparam int OP_W     = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ    = 3'd0,
      OP_DEQ    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_SEARCH = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;        // write word into the cell at the tail
      logic pop;         // every cell takes its neighbor's word
      logic load_match;  // capture compare result
      logic scan;        // match bits move one cell toward the head
   } cell_ctrl_type;

endpackage

// ===== sv/shift_fifo_with_search_top.sv =====
// Top level of the shift queue with search: control, capacity register and cell chain.
//
// Enqueue, dequeue, peek, clear and unused op codes are taken one per cycle; the
// result appears in the cycle after the op is accepted and busy stays low. A search
// compares all held entries at once, then shifts the match flags one cell toward
// the head per cycle until the first match reaches the head or every held entry
// has been passed on a miss; busy is high meanwhile and the result appears as busy
// falls. A search on an empty queue answers at once. Each result word is on the
// rsp_ ports for exactly one cycle with rsp_strobe high and is not held for the
// receiver. Capacity writes are always ready.
module shift_fifo_with_search_top #(
   parameter int DEPTH = sfs_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sfs_pkg::OP_W-1:0]            req_op,
   input  logic signed [sfs_pkg::WORD_W-1:0]   req_data_word,
   output logic                                rsp_strobe,
   output logic [sfs_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [sfs_pkg::WORD_W-1:0]   rsp_value,
   output logic [sfs_pkg::POS_W-1:0]           rsp_position,
   output logic [sfs_pkg::COUNT_W-1:0]         rsp_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfs_pkg::CAP_W-1:0]           csr_capacity
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = (CW > sfs_pkg::CAP_W) ? CW : sfs_pkg::CAP_W;

   sfs_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [sfs_pkg::CAP_W-1:0] cap_ff;
   sfs_pkg::cell_ctrl_type ctrl;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [sfs_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [sfs_pkg::WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [sfs_pkg::POS_W-1:0]         rsp_position_ff, rsp_position_in;
   logic [sfs_pkg::COUNT_W-1:0]       rsp_count_ff;

   logic signed [sfs_pkg::WORD_W-1:0] data_chain [DEPTH];
   logic                              match_chain [DEPTH];

   logic is_full;
   logic scan_last;

   // capacity above DEPTH saturates: the fill == DEPTH term covers it
   assign is_full   = (KW'(fill_ff) >= KW'(cap_ff)) || (fill_ff == CW'(DEPTH));
   assign scan_last = (CW'(pos_ff) + CW'(1)) >= fill_ff;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [sfs_pkg::WORD_W-1:0] nxt_data;
         logic                              nxt_match;
         if (g == DEPTH - 1) begin : g_tail
            assign nxt_data  = data_chain[g];
            assign nxt_match = 1'b0;
         end else begin : g_mid
            assign nxt_data  = data_chain[g+1];
            assign nxt_match = match_chain[g+1];
         end
         sfs_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .fill       (fill_ff),
            .word       (req_data_word),
            .next_data  (nxt_data),
            .next_match (nxt_match),
            .data       (data_chain[g]),
            .match      (match_chain[g])
         );
      end
   endgenerate

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      pos_in          = pos_ff;
      ctrl            = '0;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = sfs_pkg::STAT_OK;
      rsp_value_in    = '0;
      rsp_position_in = '0;
      unique case (state_ff)
         sfs_pkg::ST_IDLE: begin
            if (start) begin
               rsp_strobe_in = 1'b1;
               unique case (req_op)
                  sfs_pkg::OP_ENQ: begin
                     if (is_full) begin
                        rsp_status_in = sfs_pkg::STAT_FULL;
                     end else begin
                        ctrl.push = 1'b1;
                        fill_in   = fill_ff + CW'(1);
                     end
                  end
                  sfs_pkg::OP_DEQ: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = sfs_pkg::STAT_EMPTY;
                     end else begin
                        rsp_value_in = data_chain[0];
                        ctrl.pop     = 1'b1;
                        fill_in      = fill_ff - CW'(1);
                     end
                  end
                  sfs_pkg::OP_PEEK: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = sfs_pkg::STAT_EMPTY;
                     end else begin
                        rsp_value_in = data_chain[0];
                     end
                  end
                  sfs_pkg::OP_CLEAR: begin
                     fill_in = '0;
                  end
                  sfs_pkg::OP_SEARCH: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = sfs_pkg::STAT_NOTFOUND;
                     end else begin
                        rsp_strobe_in   = 1'b0;
                        ctrl.load_match = 1'b1;
                        pos_in          = '0;
                        state_in        = sfs_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sfs_pkg::ST_SCAN: begin
            // head cell holds the match flag of entry pos_ff
            if (match_chain[0]) begin
               rsp_strobe_in   = 1'b1;
               rsp_position_in = sfs_pkg::POS_W'(pos_ff);
               state_in        = sfs_pkg::ST_IDLE;
            end else if (scan_last) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = sfs_pkg::STAT_NOTFOUND;
               state_in      = sfs_pkg::ST_IDLE;
            end else begin
               ctrl.scan = 1'b1;
               pos_in    = pos_ff + AW'(1);
            end
         end
         default: begin
            state_in = sfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfs_pkg::ST_IDLE;
         fill_ff       <= '0;
         pos_ff        <= '0;
         cap_ff        <= sfs_pkg::CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= sfs_pkg::COUNT_W'(fill_in);
   end

   assign busy         = (state_ff == sfs_pkg::ST_SCAN);
   assign csr_ready    = 1'b1;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

// ===== sv/sfs_cell.sv =====
// One queue cell: holds an entry and a match flag, both shift toward the head.
module sfs_cell #(
   parameter int DEPTH = sfs_pkg::DEPTH_DEF,
   parameter int INDEX = 0,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sfs_pkg::cell_ctrl_type            ctrl,
   input  logic [CW-1:0]                     fill,
   input  logic signed [sfs_pkg::WORD_W-1:0] word,
   input  logic signed [sfs_pkg::WORD_W-1:0] next_data,
   input  logic                              next_match,
   output logic signed [sfs_pkg::WORD_W-1:0] data,
   output logic                              match
);

   logic signed [sfs_pkg::WORD_W-1:0] data_ff, data_in;
   logic                              match_ff, match_in;
   logic                              held;

   assign held = CW'(INDEX) < fill;

   always_comb begin
      data_in = data_ff;
      if (ctrl.push && fill == CW'(INDEX)) begin
         data_in = word;
      end else if (ctrl.pop) begin
         data_in = next_data;
      end
   end

   always_comb begin
      match_in = match_ff;
      if (ctrl.load_match) begin
         match_in = held && (data_ff == word);
      end else if (ctrl.scan) begin
         match_in = next_match;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule
